/* src/json_string_unescape_decoder_assert.svh */
// Assertion macros shared by the string unescape decoder modules.
// Expects clk and rst_n in the scope of the module that includes it.
`ifndef JSON_STRING_UNESCAPE_DECODER_ASSERT_SVH
`define JSON_STRING_UNESCAPE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define JSU_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication, disabled during reset
`define JSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

/* src/jsu_pkg.sv */
// Shared types and codes for the JSON string unescape decoder.
// No dependencies; used by the front, queue, back and top modules.
package jsu_pkg;

    // Default depth of the command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] RESULT_BYTE  = 2'd0;
    localparam logic [1:0] RESULT_DONE  = 2'd1;
    localparam logic [1:0] RESULT_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE     = 3'd1;
    localparam logic [2:0] ERR_UNTERM_ESC   = 3'd2;
    localparam logic [2:0] ERR_SHORT_UNI    = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd4;
    localparam logic [2:0] ERR_UNTERM_STR   = 3'd5;
    localparam logic [2:0] ERR_BAD_HEX      = 3'd6;

    // Work handed from front to back
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_DONE,
        CMD_ERROR,
        CMD_UTF8
    } cmd_kind_t;

    // value: byte in [7:0], error code in [2:0], or 16-bit code point
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] value;
    } cmd_t;

endpackage

/* src/jsu_queue.sv */
// Small register FIFO carrying commands from the front to the back.
// Depends on jsu_pkg and the assertion macro header.
`include "json_string_unescape_decoder_assert.svh"

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output jsu_pkg::cmd_t head,
    output logic          head_valid
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    `JSU_ASSERT_IMPLIES(a_no_overflow, push, !full)
    `JSU_ASSERT_IMPLIES(a_no_underflow, pop, head_valid)
    `JSU_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

/* src/jsu_front.sv */
// Front end: accepts text bytes, tracks string/escape/unicode state and
// emits one command per item that yields results. Depends on jsu_pkg.
module jsu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          text_valid,
    output logic          text_ready,
    input  logic [7:0]    text_byte,
    input  logic          end_of_text,
    input  logic          q_full,
    output logic          push,
    output jsu_pkg::cmd_t push_cmd
);
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_STR,
        PH_ESC,
        PH_HEX
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_point_reg, code_point_next;
    logic        accept;
    logic        has_cmd;
    cmd_t        cmd;
    logic [4:0]  hex;
    logic [15:0] cp_shifted;

    // Hex digit decode: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]})
        begin
            r = {1'b1, b[3:0]};
        end
        else if (b inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    assign text_ready = !q_full;
    assign accept     = text_valid && text_ready;
    assign hex        = hex_decode(text_byte);
    assign cp_shifted = {code_point_reg[11:0], hex[3:0]};

    // Next state and command
    always_comb
    begin
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        code_point_next = code_point_reg;
        has_cmd         = 1'b0;
        cmd.kind        = CMD_BYTE;
        cmd.value       = {8'd0, text_byte};
        case (phase_reg)
            PH_STR:
            begin
                if (end_of_text)
                begin
                    has_cmd    = 1'b1;
                    cmd.kind   = CMD_ERROR;
                    cmd.value  = {13'd0, ERR_UNTERM_STR};
                    phase_next = PH_WAIT;
                end
                else if (text_byte == 8'h22)
                begin
                    has_cmd    = 1'b1;
                    cmd.kind   = CMD_DONE;
                    phase_next = PH_WAIT;
                end
                else if (text_byte == 8'h5C)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    has_cmd = 1'b1;
                end
            end
            PH_ESC:
            begin
                phase_next = PH_STR;
                has_cmd    = 1'b1;
                if (end_of_text)
                begin
                    cmd.kind   = CMD_ERROR;
                    cmd.value  = {13'd0, ERR_UNTERM_ESC};
                    phase_next = PH_WAIT;
                end
                else
                begin
                    case (text_byte)
                        8'h22, 8'h5C, 8'h2F: cmd.value = {8'd0, text_byte};
                        8'h62: cmd.value = 16'h0008;
                        8'h66: cmd.value = 16'h000C;
                        8'h6E: cmd.value = 16'h000A;
                        8'h72: cmd.value = 16'h000D;
                        8'h74: cmd.value = 16'h0009;
                        8'h75:
                        begin
                            has_cmd    = 1'b0;
                            phase_next = PH_HEX;
                        end
                        default:
                        begin
                            cmd.kind   = CMD_ERROR;
                            cmd.value  = {13'd0, ERR_UNKNOWN_ESC};
                            phase_next = PH_WAIT;
                        end
                    endcase
                end
                hex_count_next  = 2'd0;
                code_point_next = 16'd0;
            end
            PH_HEX:
            begin
                if (end_of_text || !hex[4])
                begin
                    has_cmd         = 1'b1;
                    cmd.kind        = CMD_ERROR;
                    cmd.value       = {13'd0, end_of_text ? ERR_SHORT_UNI : ERR_BAD_HEX};
                    phase_next      = PH_WAIT;
                    hex_count_next  = 2'd0;
                    code_point_next = 16'd0;
                end
                else if (hex_count_reg == 2'd3)
                begin
                    has_cmd         = 1'b1;
                    cmd.kind        = CMD_UTF8;
                    cmd.value       = cp_shifted;
                    phase_next      = PH_STR;
                    hex_count_next  = 2'd0;
                    code_point_next = 16'd0;
                end
                else
                begin
                    hex_count_next  = hex_count_reg + 2'd1;
                    code_point_next = cp_shifted;
                end
            end
            default:
            begin
                if (end_of_text || !(text_byte inside {8'h22, 8'h20, 8'h09, 8'h0A, 8'h0D}))
                begin
                    has_cmd   = 1'b1;
                    cmd.kind  = CMD_ERROR;
                    cmd.value = {13'd0, ERR_NO_QUOTE};
                end
                else if (text_byte == 8'h22)
                begin
                    phase_next = PH_STR;
                end
                hex_count_next  = 2'd0;
                code_point_next = 16'd0;
            end
        endcase
    end

    assign push     = accept && has_cmd;
    assign push_cmd = cmd;

    // Decoder state, advances only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            hex_count_reg  <= 2'd0;
            code_point_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            code_point_reg <= code_point_next;
        end
    end

endmodule

/* src/jsu_back.sv */
// Back end: expands queued commands into result items (1 to 3 UTF-8 bytes
// for a code point) into a registered output stage. Depends on jsu_pkg.
`include "json_string_unescape_decoder_assert.svh"

module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  jsu_pkg::cmd_t head,
    output logic          pop,
    output logic          result_valid,
    input  logic          result_ready,
    output logic [7:0]    data_byte,
    output logic [1:0]    result_kind,
    output logic [2:0]    error_code,
    output logic          last_of_run
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic [1:0] kind_reg, kind_next;
    logic [2:0] err_reg, err_next;
    logic       last_reg, last_next;
    logic       load;
    logic [1:0] count;
    logic       is_last;

    assign load = head_valid && (!valid_reg || result_ready);

    // Number of result items for the head command
    always_comb
    begin
        count = 2'd1;
        if (head.kind == CMD_UTF8)
        begin
            if (head.value >= 16'h0800)
            begin
                count = 2'd3;
            end
            else if (head.value >= 16'h0080)
            begin
                count = 2'd2;
            end
        end
    end

    assign is_last = (idx_reg == count - 2'd1);

    // Result item for the current position within the head command
    always_comb
    begin
        data_next = 8'd0;
        kind_next = RESULT_BYTE;
        err_next  = ERR_NONE;
        case (head.kind)
            CMD_BYTE: data_next = head.value[7:0];
            CMD_DONE: kind_next = RESULT_DONE;
            CMD_ERROR:
            begin
                kind_next = RESULT_ERROR;
                err_next  = head.value[2:0];
            end
            CMD_UTF8:
            begin
                if (count == 2'd1)
                begin
                    data_next = head.value[7:0];
                end
                else if (idx_reg == 2'd0)
                begin
                    data_next = (count == 2'd2) ? {3'b110, head.value[10:6]}
                                                : {4'b1110, head.value[15:12]};
                end
                else if (is_last)
                begin
                    data_next = {2'b10, head.value[5:0]};
                end
                else
                begin
                    data_next = {2'b10, head.value[11:6]};
                end
            end
            default: data_next = 8'd0;
        endcase
        last_next = is_last;
    end

    assign pop        = load && is_last;
    assign idx_next   = load ? (is_last ? 2'd0 : idx_reg + 2'd1) : idx_reg;
    assign valid_next = load || (valid_reg && !result_ready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            kind_reg <= kind_next;
            err_reg  <= err_next;
            last_reg <= last_next;
        end
    end

    assign result_valid = valid_reg;
    assign data_byte    = data_reg;
    assign result_kind  = kind_reg;
    assign error_code   = err_reg;
    assign last_of_run  = last_reg;

    `JSU_ASSERT_IMPLIES(a_mid_run_utf8, idx_reg != 2'd0, head_valid && head.kind == CMD_UTF8)
    `JSU_ASSERT_IMPLIES(a_error_is_last, valid_reg && kind_reg == RESULT_ERROR, last_reg)
    `JSU_ASSERT_IMPLIES(a_err_only_on_error, valid_reg && kind_reg != RESULT_ERROR, err_reg == ERR_NONE)

endmodule

/* src/json_string_unescape_decoder.sv */
// Each command passes through the queue, then the back end's output register.
// Throughput: one text item per cycle while the command queue has room; the
// back end delivers one result item per cycle while result_ready is high, so a
// \u escape expanding to three UTF-8 bytes holds the back end for all three bytes.
// Reset (rst_n low, asynchronous): waiting for an opening quote, queue empty,
// no result valid.
module json_string_unescape_decoder #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] data_byte,
    output logic [1:0] result_kind,
    output logic [2:0] error_code,
    output logic       last_of_run
);
    import jsu_pkg::*;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head;
    logic head_valid;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_byte  (text_byte),
        .end_of_text(end_of_text),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    jsu_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .head_valid(head_valid)
    );

    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .data_byte   (data_byte),
        .result_kind (result_kind),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

endmodule
